/* design/c5ss_pkg.sv */
// ----------------------------------------------------------------------------
// c5ss_pkg
// Shared constants and types of the streaming 5x5 convolution core.
// ----------------------------------------------------------------------------
`default_nettype none

package c5ss_pkg;

  // Kernel geometry: a 5x5 window centered on the output position.
  localparam int KSIZE = 5;
  localparam int KHALF = 2;

  // The sum is divided by 16 (truncating toward zero) and clamped to -16..16.
  localparam int SCALE_SHIFT = 4;
  localparam int SAT_HI      = 16;
  localparam int SAT_LO      = -16;
  localparam int RESULT_W    = 6;

  // Register file layout.
  localparam int COEF_REG_W = 40;
  localparam int SIZE_REG_W = 11;
  localparam int SIZE_RESET = 1024;
  localparam int CFG_IDX_W  = 3;

  localparam logic [CFG_IDX_W-1:0] REG_COEF_LAST    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd6;

  // Queue depths between the front end, the datapath and the output.
  localparam int MID_DEPTH = 4;
  localparam int OUT_DEPTH = 8;

  // One register write as seen by the front end and the datapath.
  typedef struct packed {
    logic                  we;
    logic [CFG_IDX_W-1:0]  idx;
    logic [COEF_REG_W-1:0] data;
  } cfg_wr_t;

  // Control that the front end attaches to every item it passes on.
  typedef struct packed {
    logic             emit;    // item produces a result
    logic             last;    // result closes the frame
    logic [KSIZE-1:0] row_ok;  // kernel row lies inside the image
    logic [KSIZE-1:0] col_ok;  // kernel column lies inside the image
  } item_ctrl_t;

  // One result item.
  typedef struct packed {
    logic signed [RESULT_W-1:0] value;
    logic                       last;
  } out_item_t;

endpackage

`default_nettype wire

/* design/conv5x5_scale_saturate_core.sv */
// ----------------------------------------------------------------------------
// conv5x5_scale_saturate_core
// Streaming 5x5 convolution with zero padding, divide by 16 and saturation.
// ----------------------------------------------------------------------------
// Pixels arrive in raster order and the core sustains one item per clock
// cycle while the output queue has room: the 25 taps are multiplied in
// parallel and each of the four line memories is read and written once per
// item. A result comes out 2*width+2 items behind its center pixel, so the
// feeder sends drain items after the last pixel of a frame; the final result
// carries last_in_frame. Results pass stages a to f on the way out. Line
// memories are not cleared after reset: whatever they hold lies outside the
// image of the current frame and is masked by the padding, so the core is
// ready immediately. Writing image_width or image_height restarts the frame.
// ----------------------------------------------------------------------------
`default_nettype none

module conv5x5_scale_saturate_core #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int PIXEL_BITS = 16,
  parameter int COEF_BITS  = 8
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  // Configuration writes.
  input  logic                                    cfg_we_i,
  input  logic [c5ss_pkg::CFG_IDX_W-1:0]          cfg_idx_i,
  input  logic [c5ss_pkg::COEF_REG_W-1:0]         cfg_data_i,
  // Input items.
  input  logic                                    push,
  output logic                                    full,
  input  logic                                    kind_i,
  input  logic signed [PIXEL_BITS-1:0]            pixel_value_i,
  // Result items.
  output logic                                    empty,
  input  logic                                    pop,
  output logic signed [c5ss_pkg::RESULT_W-1:0]    result_value_o,
  output logic                                    last_in_frame_o
);

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int MID_W = $bits(c5ss_pkg::item_ctrl_t) + PIXEL_BITS + CW;
  localparam int OUT_W = $bits(c5ss_pkg::out_item_t);

  c5ss_pkg::cfg_wr_t    cfg;
  logic                 mid_push, mid_pop, mid_full, mid_empty;
  logic [MID_W-1:0]     mid_wdata, mid_rdata;
  c5ss_pkg::item_ctrl_t front_ctrl, back_ctrl;
  logic signed [PIXEL_BITS-1:0] front_pix, back_pix;
  logic [CW-1:0]        front_addr, back_addr;
  logic                 res_push, res_full, res_pop;
  c5ss_pkg::out_item_t  res_in, res_out;

  assign cfg = '{we: cfg_we_i, idx: cfg_idx_i, data: cfg_data_i};

  // Front end: position tracking and classification.
  c5ss_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .push_i       (push),
    .kind_i       (kind_i),
    .pixel_i      (pixel_value_i),
    .queue_full_i (mid_full),
    .queue_push_o (mid_push),
    .pix_o        (front_pix),
    .addr_o       (front_addr),
    .ctrl_o       (front_ctrl)
  );

  assign full      = mid_full;
  assign mid_wdata = {front_ctrl, front_pix, front_addr};
  assign {back_ctrl, back_pix, back_addr} = mid_rdata;

  // Queue between classification and the datapath.
  c5ss_fifo #(
    .WIDTH (MID_W),
    .DEPTH (c5ss_pkg::MID_DEPTH)
  ) u_mid_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (mid_push),
    .wdata_i (mid_wdata),
    .pop_i   (mid_pop),
    .rdata_o (mid_rdata),
    .full_o  (mid_full),
    .empty_o (mid_empty)
  );

  // Datapath.
  c5ss_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .PIXEL_BITS (PIXEL_BITS),
    .COEF_BITS  (COEF_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .queue_empty_i (mid_empty),
    .ctrl_i        (back_ctrl),
    .pix_i         (back_pix),
    .addr_i        (back_addr),
    .queue_pop_o   (mid_pop),
    .result_pop_i  (res_pop),
    .result_push_o (res_push),
    .result_o      (res_in)
  );

  // Output queue.
  assign res_pop = pop && !empty;

  c5ss_fifo #(
    .WIDTH (OUT_W),
    .DEPTH (c5ss_pkg::OUT_DEPTH)
  ) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .wdata_i (res_in),
    .pop_i   (pop),
    .rdata_o (res_out),
    .full_o  (res_full),
    .empty_o (empty)
  );

  assign result_value_o  = res_out.value;
  assign last_in_frame_o = res_out.last;

  // The credit scheme must never let a result meet a full output queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni) res_push |-> !res_full)
    else $error("result pushed into a full output queue");

  // The front end only forwards items that were actually accepted.
  assert property (@(posedge clk_i) disable iff (!rst_ni) mid_push |-> (push && !full))
    else $error("item forwarded without an accepted input");

  // Every offered result lies inside the saturation range.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      !empty |-> ((result_value_o <= 6'sd16) && (result_value_o >= -6'sd16)))
    else $error("result outside the saturation range");

endmodule

`default_nettype wire

/* design/c5ss_fifo.sv */
// ----------------------------------------------------------------------------
// c5ss_fifo
// Small register-based first-in first-out queue with full and empty flags.
// ----------------------------------------------------------------------------
`default_nettype none

module c5ss_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             full_o,
  output logic             empty_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [NW-1:0]    count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == NW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  // Pointer and fill-level update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + NW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - NW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage holds payload only.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

/* design/c5ss_front.sv */
// ----------------------------------------------------------------------------
// c5ss_front
// Front end: accepts items, tracks the raster position of input and output,
// drops early drains and tags each remaining item with its result control.
// ----------------------------------------------------------------------------
`default_nettype none

module c5ss_front #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int PIXEL_BITS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  c5ss_pkg::cfg_wr_t                 cfg_i,
  input  logic                              push_i,
  input  logic                              kind_i,
  input  logic signed [PIXEL_BITS-1:0]      pixel_i,
  input  logic                              queue_full_i,
  output logic                              queue_push_o,
  output logic signed [PIXEL_BITS-1:0]      pix_o,
  output logic [$clog2(MAX_WIDTH)-1:0]      addr_o,
  output c5ss_pkg::item_ctrl_t              ctrl_o
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int RW = $clog2(MAX_HEIGHT + 4);
  localparam int OW = $clog2(MAX_HEIGHT);

  // Clamp a written size to 1..maximum.
  function automatic logic [WW-1:0] clamp_w(logic [c5ss_pkg::SIZE_REG_W-1:0] v);
    logic [WW-1:0] r;
    if (v == '0) begin
      r = WW'(1);
    end else if (32'(v) > MAX_WIDTH) begin
      r = WW'(MAX_WIDTH);
    end else begin
      r = WW'(v);
    end
    return r;
  endfunction

  function automatic logic [HW-1:0] clamp_h(logic [c5ss_pkg::SIZE_REG_W-1:0] v);
    logic [HW-1:0] r;
    if (v == '0) begin
      r = HW'(1);
    end else if (32'(v) > MAX_HEIGHT) begin
      r = HW'(MAX_HEIGHT);
    end else begin
      r = HW'(v);
    end
    return r;
  endfunction

  logic [WW-1:0] w_q;
  logic [HW-1:0] h_q;
  logic [CW-1:0] in_col_q, in_col_d;
  logic [RW-1:0] in_row_q, in_row_d;
  logic [CW-1:0] out_col_q, out_col_d;
  logic [OW-1:0] out_row_q, out_row_d;

  logic          accept, pixel_slot, process;
  logic          warm, out_last, col_wrap, out_col_wrap;
  logic [CW-1:0] w_last;
  logic [OW-1:0] h_last;
  logic          size_write;

  assign accept       = push_i && !queue_full_i;
  assign pixel_slot   = 32'(in_row_q) < 32'(h_q);
  assign process      = accept && !(kind_i && pixel_slot);
  assign w_last       = CW'(w_q - WW'(1));
  assign h_last       = OW'(h_q - HW'(1));
  assign col_wrap     = (in_col_q == w_last);
  assign out_col_wrap = (out_col_q == w_last);
  assign out_last     = warm && (out_row_q == h_last) && out_col_wrap;
  assign size_write   = cfg_i.we && ((cfg_i.idx == c5ss_pkg::REG_IMAGE_WIDTH) ||
                                     (cfg_i.idx == c5ss_pkg::REG_IMAGE_HEIGHT));

  // Warm-up: a result exists once the input slot reaches 2*width+2.
  always_comb begin
    int row;
    row  = int'(in_row_q);
    warm = (row > c5ss_pkg::KHALF + 1) ||
           ((row == c5ss_pkg::KHALF + 1) && (int'(w_q) >= c5ss_pkg::KHALF)) ||
           ((row == c5ss_pkg::KHALF) && (int'(in_col_q) >= c5ss_pkg::KHALF));
  end

  // Zero padding: which kernel rows and columns fall inside the image.
  always_comb begin
    int rr;
    int cc;
    ctrl_o.emit = warm;
    ctrl_o.last = out_last;
    for (int k = 0; k < c5ss_pkg::KSIZE; k++) begin
      rr = int'(out_row_q) + c5ss_pkg::KHALF - k;
      cc = int'(out_col_q) + c5ss_pkg::KHALF - k;
      ctrl_o.row_ok[k] = (rr >= 0) && (rr < int'(h_q));
      ctrl_o.col_ok[k] = (cc >= 0) && (cc < int'(w_q));
    end
  end

  // Item passed on to the datapath; drain slots feed zeros.
  assign queue_push_o = process;
  assign pix_o        = pixel_slot ? pixel_i : '0;
  assign addr_o       = in_col_q;

  // Position counters.
  always_comb begin
    in_col_d  = in_col_q;
    in_row_d  = in_row_q;
    out_col_d = out_col_q;
    out_row_d = out_row_q;
    if (process) begin
      if (col_wrap) begin
        in_col_d = '0;
        in_row_d = in_row_q + RW'(1);
      end else begin
        in_col_d = in_col_q + CW'(1);
      end
      if (warm) begin
        if (out_col_wrap) begin
          out_col_d = '0;
          out_row_d = out_row_q + OW'(1);
        end else begin
          out_col_d = out_col_q + CW'(1);
        end
      end
    end
    // The final result of a frame and a size change both restart the frame.
    if ((process && out_last) || size_write) begin
      in_col_d  = '0;
      in_row_d  = '0;
      out_col_d = '0;
      out_row_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q       <= clamp_w(c5ss_pkg::SIZE_REG_W'(c5ss_pkg::SIZE_RESET));
      h_q       <= clamp_h(c5ss_pkg::SIZE_REG_W'(c5ss_pkg::SIZE_RESET));
      in_col_q  <= '0;
      in_row_q  <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
    end else begin
      if (cfg_i.we && (cfg_i.idx == c5ss_pkg::REG_IMAGE_WIDTH)) begin
        w_q <= clamp_w(cfg_i.data[c5ss_pkg::SIZE_REG_W-1:0]);
      end
      if (cfg_i.we && (cfg_i.idx == c5ss_pkg::REG_IMAGE_HEIGHT)) begin
        h_q <= clamp_h(cfg_i.data[c5ss_pkg::SIZE_REG_W-1:0]);
      end
      in_col_q  <= in_col_d;
      in_row_q  <= in_row_d;
      out_col_q <= out_col_d;
      out_row_q <= out_row_d;
    end
  end

endmodule

`default_nettype wire

/* design/c5ss_back.sv */
// ----------------------------------------------------------------------------
// c5ss_back
// Datapath: four line memories, the 5x5 window, 25 parallel multipliers,
// a registered adder tree, scaling and saturation. No internal stalls; items
// enter only while the output queue has room for everything in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module c5ss_back #(
  parameter int MAX_WIDTH  = 1024,
  parameter int PIXEL_BITS = 16,
  parameter int COEF_BITS  = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  c5ss_pkg::cfg_wr_t             cfg_i,
  input  logic                          queue_empty_i,
  input  c5ss_pkg::item_ctrl_t          ctrl_i,
  input  logic signed [PIXEL_BITS-1:0]  pix_i,
  input  logic [$clog2(MAX_WIDTH)-1:0]  addr_i,
  output logic                          queue_pop_o,
  input  logic                          result_pop_i,
  output logic                          result_push_o,
  output c5ss_pkg::out_item_t           result_o
);

  localparam int K      = c5ss_pkg::KSIZE;
  localparam int CW     = $clog2(MAX_WIDTH);
  localparam int PROD_W = PIXEL_BITS + COEF_BITS;
  localparam int ROW_W  = PROD_W + 3;
  localparam int SUM_W  = ROW_W + 3;
  localparam int UW     = $clog2(c5ss_pkg::OUT_DEPTH + 1);
  localparam int EXT_W  = (K * COEF_BITS > c5ss_pkg::COEF_REG_W) ?
                          K * COEF_BITS : c5ss_pkg::COEF_REG_W;

  localparam logic signed [SUM_W-1:0] BIAS     = SUM_W'((1 << c5ss_pkg::SCALE_SHIFT) - 1);
  localparam logic signed [SUM_W-1:0] SAT_HI_S = SUM_W'(c5ss_pkg::SAT_HI);
  localparam logic signed [SUM_W-1:0] SAT_LO_S = SUM_W'(c5ss_pkg::SAT_LO);

  // Coefficient registers.
  logic [c5ss_pkg::COEF_REG_W-1:0] coef_q [K];
  logic signed [COEF_BITS-1:0]     coef [K][K];

  // Pipeline control.
  logic [UW-1:0] used_q, used_d;
  logic          take, drop;
  logic          a_valid_q, b_valid_q, c_valid_q, d_valid_q, e_valid_q, f_valid_q;
  logic          fwd_q;

  // Pipeline payload.
  logic signed [PIXEL_BITS-1:0] a_pix_q, b_pix_q;
  logic [CW-1:0]                a_addr_q, b_addr_q;
  c5ss_pkg::item_ctrl_t         a_ctrl_q, b_ctrl_q, c_ctrl_q, d_ctrl_q, e_ctrl_q, f_ctrl_q;
  logic [PIXEL_BITS-1:0]        rd [K-1];
  logic signed [PIXEL_BITS-1:0] fwd_col_q [K-1];
  logic signed [PIXEL_BITS-1:0] b_col [K];
  logic signed [PIXEL_BITS-1:0] win_q [K][K];
  logic signed [PROD_W-1:0]     prod_q [K][K];
  logic signed [ROW_W-1:0]      row_sum_q [K];
  logic signed [SUM_W-1:0]      total_q;
  logic signed [SUM_W-1:0]      biased, quot;

  // Unpack coefficient kc of row kr from its field in the row register.
  always_comb begin
    logic [EXT_W-1:0] ext;
    for (int kr = 0; kr < K; kr++) begin
      ext = EXT_W'(coef_q[kr]);
      for (int kc = 0; kc < K; kc++) begin
        coef[kr][kc] = ext[kc*COEF_BITS +: COEF_BITS];
      end
    end
  end

  // Admission: every item in flight has a reserved output queue slot.
  assign take        = !queue_empty_i && (32'(used_q) < c5ss_pkg::OUT_DEPTH);
  assign queue_pop_o = take;
  assign drop        = f_valid_q && !f_ctrl_q.emit;
  assign used_d      = used_q + UW'(take) - UW'(result_pop_i) - UW'(drop);

  // Line memories: read while the item is in stage a, written in stage b.
  for (genvar j = 0; j < K - 1; j++) begin : g_line
    logic [PIXEL_BITS-1:0] mem_q [MAX_WIDTH];
    logic [PIXEL_BITS-1:0] rd_q;
    always_ff @(posedge clk_i) begin
      if (b_valid_q) begin
        mem_q[b_addr_q] <= b_col[j];
      end
      if (a_valid_q) begin
        rd_q <= mem_q[a_addr_q];
      end
    end
    assign rd[j] = rd_q;
  end

  // New window column; back-to-back items at one address take the bypass.
  always_comb begin
    b_col[0] = b_pix_q;
    for (int j = 1; j < K; j++) begin
      b_col[j] = fwd_q ? fwd_col_q[j-1] : rd[j-1];
    end
  end

  // Scale by 1/16 toward zero, then saturate.
  assign biased = total_q + (total_q[SUM_W-1] ? BIAS : '0);
  assign quot   = biased >>> c5ss_pkg::SCALE_SHIFT;

  always_comb begin
    result_o.last = f_ctrl_q.last;
    if (quot > SAT_HI_S) begin
      result_o.value = c5ss_pkg::RESULT_W'(c5ss_pkg::SAT_HI);
    end else if (quot < SAT_LO_S) begin
      result_o.value = c5ss_pkg::RESULT_W'(c5ss_pkg::SAT_LO);
    end else begin
      result_o.value = c5ss_pkg::RESULT_W'(quot);
    end
  end

  assign result_push_o = f_valid_q && f_ctrl_q.emit;

  // Control registers and coefficients.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q    <= '0;
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
      d_valid_q <= 1'b0;
      e_valid_q <= 1'b0;
      f_valid_q <= 1'b0;
      fwd_q     <= 1'b0;
      for (int kr = 0; kr < K; kr++) begin
        coef_q[kr] <= '0;
      end
    end else begin
      used_q    <= used_d;
      a_valid_q <= take;
      b_valid_q <= a_valid_q;
      c_valid_q <= b_valid_q;
      d_valid_q <= c_valid_q;
      e_valid_q <= d_valid_q;
      f_valid_q <= e_valid_q;
      fwd_q     <= a_valid_q && b_valid_q && (a_addr_q == b_addr_q);
      if (cfg_i.we && (cfg_i.idx <= c5ss_pkg::REG_COEF_LAST)) begin
        coef_q[cfg_i.idx] <= cfg_i.data;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    logic signed [ROW_W-1:0] row_acc;
    logic signed [SUM_W-1:0] sum_acc;
    // Stage a: item taken from the queue.
    a_pix_q  <= pix_i;
    a_addr_q <= addr_i;
    a_ctrl_q <= ctrl_i;
    // Stage b: memory data arrives.
    b_pix_q  <= a_pix_q;
    b_addr_q <= a_addr_q;
    b_ctrl_q <= a_ctrl_q;
    for (int j = 0; j < K - 1; j++) begin
      fwd_col_q[j] <= b_col[j];
    end
    // Stage c: window shifts in the new column.
    c_ctrl_q <= b_ctrl_q;
    if (b_valid_q) begin
      for (int i = 0; i < K; i++) begin
        for (int t = K - 1; t > 0; t--) begin
          win_q[i][t] <= win_q[i][t-1];
        end
        win_q[i][0] <= b_col[i];
      end
    end
    // Stage d: products, zero outside the image.
    d_ctrl_q <= c_ctrl_q;
    for (int i = 0; i < K; i++) begin
      for (int t = 0; t < K; t++) begin
        if (c_ctrl_q.row_ok[i] && c_ctrl_q.col_ok[t]) begin
          prod_q[i][t] <= win_q[i][t] * coef[i][t];
        end else begin
          prod_q[i][t] <= '0;
        end
      end
    end
    // Stage e: one sum per kernel row.
    e_ctrl_q <= d_ctrl_q;
    for (int i = 0; i < K; i++) begin
      row_acc = '0;
      for (int t = 0; t < K; t++) begin
        row_acc = row_acc + ROW_W'(prod_q[i][t]);
      end
      row_sum_q[i] <= row_acc;
    end
    // Stage f: total of the row sums.
    f_ctrl_q <= e_ctrl_q;
    sum_acc = '0;
    for (int i = 0; i < K; i++) begin
      sum_acc = sum_acc + SUM_W'(row_sum_q[i]);
    end
    total_q <= sum_acc;
  end

endmodule

`default_nettype wire
